// File: design/mrs_pkg.sv
// Shared types, marker tables and the end-marker matcher step for the markup region stripper.
// Used by every module of the block by scoped names; depends on nothing else.
`default_nettype none

package mrs_pkg;

	typedef enum logic [1:0] {
		KIND_SCRIPT,
		KIND_STYLE,
		KIND_COMMENT,
		KIND_NOSCRIPT
	} kind_t;

	localparam int MARK_MAX    = 11;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Marker positions and byte counts per item (at most nine results) fit in four bits.
	typedef logic [3:0] pos_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       stream_end;
	} out_item_t;

	// Work handed from the front to the back: emit the first 'count' bytes of the
	// string made of the first 'held' start-marker bytes followed by 'data'.
	typedef struct packed {
		kind_t      kind;
		pos_t       held;
		logic [7:0] data;
		pos_t       count;
		logic       last;
	} cmd_t;

	localparam logic [7:0] CHAR_DASH = "-";

	localparam logic [7:0] START_PAT [4][MARK_MAX] = '{
		'{"<", "s", "c", "r", "i", "p", "t", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"<", "s", "t", "y", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"<", "!", "-", "-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"<", "n", "o", "s", "c", "r", "i", "p", "t", 8'h00, 8'h00}
	};
	localparam pos_t START_LEN [4] = '{4'd7, 4'd6, 4'd4, 4'd9};

	localparam logic [7:0] END_PAT [4][MARK_MAX] = '{
		'{"<", "/", "s", "c", "r", "i", "p", "t", ">", 8'h00, 8'h00},
		'{"<", "/", "s", "t", "y", "l", "e", ">", 8'h00, 8'h00, 8'h00},
		'{"-", "-", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"<", "/", "n", "o", "s", "c", "r", "i", "p", "t", ">"}
	};
	localparam pos_t END_LEN [4] = '{4'd9, 4'd8, 4'd3, 4'd11};

	// End-marker progress right after the start marker completes. Only the comment
	// start "<!--" already ends in a partial end marker ("--").
	localparam pos_t END_INIT [4] = '{4'd0, 4'd0, 4'd2, 4'd0};

	// One step of the end-marker matcher. The opening byte of the tag markers occurs
	// nowhere else in them, so a mismatch falls back to zero or one; "-->" also
	// keeps two matched bytes when a dash follows "--".
	function automatic pos_t end_step(kind_t kind, pos_t e, logic [7:0] c);
		pos_t r;
		if (c == END_PAT[kind][e]) begin
			r = e + 4'd1;
		end else if (kind == KIND_COMMENT && e == 4'd2 && c == CHAR_DASH) begin
			r = 4'd2;
		end else if (c == END_PAT[kind][0]) begin
			r = 4'd1;
		end else begin
			r = 4'd0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/markup_region_stripper_core.sv
// The results of an item pass through the command queue and then the output register.
// Throughput: one byte per cycle in while the queue is not full; results leave one per cycle
// while dn_stall is low; a four-command queue keeps input flowing while held prefixes drain.
// Reset (arst_n low) selects script markers, clears all match state and empties the queue.
// Mode writes are taken only while the queue and the output register are empty.
`default_nettype none

module markup_region_stripper_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               up_valid,
	output logic                    up_stall,
	input  wire mrs_pkg::in_item_t  up_item,
	output logic                    dn_valid,
	input  wire logic               dn_stall,
	output mrs_pkg::out_item_t      dn_item,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_data
);

	mrs_pkg::cmd_t push_cmd;
	mrs_pkg::cmd_t head;
	logic          push;
	logic          pop;
	logic          head_valid;
	logic          q_full;
	logic          q_empty;

	assign cfg_ready = q_empty && !dn_valid;

	mrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (up_valid),
		.up_stall (up_stall),
		.up_item  (up_item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	mrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full),
		.empty      (q_empty)
	);

	mrs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.dn_valid   (dn_valid),
		.dn_stall   (dn_stall),
		.dn_item    (dn_item)
	);

endmodule

`default_nettype wire

// File: design/mrs_queue.sv
// Short command queue between the front and back parts of the stripper.
// Depends on mrs_pkg for the command type and depth.
`default_nettype none

module mrs_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mrs_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output mrs_pkg::cmd_t      head,
	output logic               head_valid,
	output logic               full,
	output logic               empty
);

	mrs_pkg::cmd_t                    store_q [mrs_pkg::QUEUE_DEPTH];
	logic [mrs_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [mrs_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [mrs_pkg::QCNT_W-1:0]       count_q;

	assign head       = store_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign empty      = (count_q == '0);
	assign full       = (count_q == mrs_pkg::QCNT_W'(mrs_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// File: design/mrs_front.sv
// Front part: accepts bytes, runs the start and end marker matchers and the mode register,
// and queues one command per item that yields results. Depends on mrs_pkg.
`default_nettype none

module mrs_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_valid,
	output logic                   up_stall,
	input  wire mrs_pkg::in_item_t up_item,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_data,
	input  wire logic              q_full,
	output logic                   push,
	output mrs_pkg::cmd_t          cmd
);

	mrs_pkg::kind_t kind_q;
	logic           region_q;
	mrs_pkg::pos_t  start_q;
	mrs_pkg::pos_t  end_q;

	logic           region_nx;
	mrs_pkg::pos_t  start_nx;
	mrs_pkg::pos_t  end_nx;
	mrs_pkg::pos_t  k1;
	mrs_pkg::pos_t  j;
	mrs_pkg::pos_t  e_step;
	mrs_pkg::pos_t  cnt;
	logic           hit;
	logic           complete;
	logic           accept;
	logic [7:0]     c;
	logic           last;

	assign up_stall = q_full;
	assign accept   = up_valid && !q_full;

	always_comb begin
		c        = up_item.data_byte;
		last     = up_item.stream_last;
		k1       = start_q + 4'd1;
		hit      = (c == mrs_pkg::START_PAT[kind_q][start_q]);
		// The start markers open with a byte that appears nowhere else in them.
		j        = hit ? k1 : ((c == mrs_pkg::START_PAT[kind_q][0]) ? 4'd1 : 4'd0);
		complete = hit && (k1 == mrs_pkg::START_LEN[kind_q]);
		e_step   = mrs_pkg::end_step(kind_q, end_q, c);

		region_nx = region_q;
		start_nx  = start_q;
		end_nx    = end_q;
		cnt       = 4'd0;

		if (!region_q) begin
			if (complete) begin
				region_nx = 1'b1;
				start_nx  = 4'd0;
				end_nx    = mrs_pkg::END_INIT[kind_q];
			end else begin
				start_nx = j;
			end
			// On the final byte the still-held tail is flushed as well.
			cnt = (last && !complete) ? k1 : (k1 - j);
		end else begin
			if (e_step == mrs_pkg::END_LEN[kind_q]) begin
				region_nx = 1'b0;
				end_nx    = 4'd0;
			end else begin
				end_nx = e_step;
			end
		end

		if (last) begin
			region_nx = 1'b0;
			start_nx  = 4'd0;
			end_nx    = 4'd0;
		end

		push      = accept && (cnt != 4'd0 || last);
		cmd.kind  = kind_q;
		cmd.held  = start_q;
		cmd.data  = c;
		cmd.count = cnt;
		cmd.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= mrs_pkg::KIND_SCRIPT;
			region_q <= 1'b0;
			start_q  <= 4'd0;
			end_q    <= 4'd0;
		end else if (cfg_we) begin
			kind_q   <= mrs_pkg::kind_t'(cfg_data);
			region_q <= 1'b0;
			start_q  <= 4'd0;
			end_q    <= 4'd0;
		end else if (accept) begin
			region_q <= region_nx;
			start_q  <= start_nx;
			end_q    <= end_nx;
		end
	end

endmodule

`default_nettype wire

// File: design/mrs_back.sv
// Back part: expands each queued command into result items, one per cycle while the output
// is not stalled, through a registered output stage. Depends on mrs_pkg.
`default_nettype none

module mrs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mrs_pkg::cmd_t  head,
	input  wire logic           head_valid,
	output logic                pop,
	output logic                dn_valid,
	input  wire logic           dn_stall,
	output mrs_pkg::out_item_t  dn_item
);

	mrs_pkg::pos_t      idx_q;
	logic               valid_q;
	mrs_pkg::out_item_t item_q;

	mrs_pkg::out_item_t item_nx;
	logic               final_one;
	logic               load;

	always_comb begin
		// A command with no bytes stands for the single empty end-of-stream result.
		final_one = (head.count == 4'd0) || (idx_q == head.count - 4'd1);
		load      = head_valid && (!valid_q || !dn_stall);
		pop       = load && final_one;

		if (head.count == 4'd0) begin
			item_nx.out_byte   = 8'h00;
			item_nx.byte_valid = 1'b0;
		end else if (idx_q < head.held) begin
			item_nx.out_byte   = mrs_pkg::START_PAT[head.kind][idx_q];
			item_nx.byte_valid = 1'b1;
		end else begin
			item_nx.out_byte   = head.data;
			item_nx.byte_valid = 1'b1;
		end
		item_nx.run_last   = final_one;
		item_nx.stream_end = final_one && head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 4'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= final_one ? 4'd0 : idx_q + 4'd1;
		end else if (!dn_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_nx;
		end
	end

	assign dn_valid = valid_q;
	assign dn_item  = item_q;

endmodule

`default_nettype wire

// File: design/mrs_checker.sv
// Port-level checks for the markup region stripper, bound to the top level.
// Depends on mrs_pkg for the item types.
`default_nettype none

module mrs_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               dn_valid,
	input  wire logic               dn_stall,
	input  wire mrs_pkg::out_item_t dn_item,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready
);

	// A result that is held back must stay in place unchanged.
	a_dn_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && dn_stall |=> dn_valid && $stable(dn_item))
		else $error("stalled result changed");

	// The end of the stream always closes the results of its item.
	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && dn_item.stream_end |-> dn_item.run_last)
		else $error("stream end without run end");

	// An empty result only marks the end of the stream and carries a zero byte.
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && !dn_item.byte_valid |-> dn_item.stream_end && dn_item.out_byte == 8'h00)
		else $error("empty result in mid stream");

	// The mode changes only while no result is pending at the output.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !dn_valid)
		else $error("mode write with result pending");

endmodule

bind markup_region_stripper_core mrs_checker u_mrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.dn_valid  (dn_valid),
	.dn_stall  (dn_stall),
	.dn_item   (dn_item),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for markup_region_stripper_core: directed table, then random
// byte streams per marker kind, checked against typed rows or a behavioral predictor.
// Depends on mrs_pkg for the item structs and the marker kind enum.
`default_nettype none

module testbench;

	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 200;
	localparam int PHASE_BYTES  = 28;
	localparam int PHASE_COUNT  = 8;

	typedef struct packed {
		logic               is_cfg;
		logic [7:0]         value;
		logic               last;
		logic               typed;
		mrs_pkg::out_item_t want;
	} step_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               up_valid  = 1'b0;
	logic               up_stall;
	mrs_pkg::in_item_t  up_item   = '0;
	logic               dn_valid;
	logic               dn_stall  = 1'b0;
	mrs_pkg::out_item_t dn_item;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_data = '0;

	markup_region_stripper_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (up_valid),
		.up_stall (up_stall),
		.up_item  (up_item),
		.dn_valid (dn_valid),
		.dn_stall (dn_stall),
		.dn_item  (dn_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Marker pairs, indexed by kind.
	string open_mark [4] = '{"<script", "<style", "<!--", "<noscript"};
	string close_mark [4] = '{"</script>", "</style>", "-->", "</noscript>"};
	string alphabet = "<>/!-scriptylenoxS";

	// Predictor state.
	mrs_pkg::kind_t cur_kind = mrs_pkg::KIND_SCRIPT;
	logic  in_region = 1'b0;
	int    open_held = 0;
	int    close_seen = 0;

	mrs_pkg::out_item_t fresh [$];
	mrs_pkg::out_item_t expected_bytes [$];
	logic [7:0] stream_bytes [$];
	int    fails = 0;
	int    burst_left = 0;
	bit    hold_req = 1'b0;

	// Directed items. Config rows carry the kind in value.
	step_t plan [26] = '{
		'{1'b0, "x",   1'b1, 1'b1, '{"x", 1'b1, 1'b1, 1'b1}},
		'{1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
		'{1'b0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
		'{1'b0, "<",   1'b1, 1'b0, '0},
		'{1'b1, 8'(mrs_pkg::KIND_COMMENT), 1'b0, 1'b0, '0},
		'{1'b0, "<",   1'b0, 1'b0, '0},
		'{1'b0, "!",   1'b0, 1'b0, '0},
		'{1'b0, "-",   1'b0, 1'b0, '0},
		'{1'b0, "-",   1'b0, 1'b0, '0},
		'{1'b0, ">",   1'b0, 1'b0, '0},
		'{1'b0, "a",   1'b1, 1'b1, '{"a", 1'b1, 1'b1, 1'b1}},
		'{1'b0, "<",   1'b0, 1'b0, '0},
		'{1'b0, "!",   1'b0, 1'b0, '0},
		'{1'b0, "<",   1'b0, 1'b0, '0},
		'{1'b0, "x",   1'b1, 1'b0, '0},
		'{1'b1, 8'(mrs_pkg::KIND_STYLE), 1'b0, 1'b0, '0},
		'{1'b0, "<",   1'b0, 1'b0, '0},
		'{1'b0, "s",   1'b0, 1'b0, '0},
		'{1'b0, "t",   1'b0, 1'b0, '0},
		'{1'b0, "y",   1'b0, 1'b0, '0},
		'{1'b0, "l",   1'b0, 1'b0, '0},
		'{1'b0, "e",   1'b0, 1'b0, '0},
		'{1'b0, "z",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{1'b1, 8'(mrs_pkg::KIND_NOSCRIPT), 1'b0, 1'b0, '0},
		'{1'b0, "<",   1'b0, 1'b0, '0},
		'{1'b0, "n",   1'b1, 1'b0, '0}
	};

	function automatic mrs_pkg::out_item_t mk_out(logic [7:0] b, logic v);
		mrs_pkg::out_item_t r;
		r.out_byte = b;
		r.byte_valid = v;
		r.run_last = 1'b0;
		r.stream_end = 1'b0;
		return r;
	endfunction

	// Longest prefix of pat that ends the first k bytes of pat followed by c.
	function automatic int advance(string pat, int k, logic [7:0] c);
		logic [7:0] s [12];
		int n, j, t;
		bit ok;
		if (k >= pat.len()) begin
			k = 0;
		end
		for (t = 0; t < k; t++) begin
			s[t] = pat[t];
		end
		s[k] = c;
		n = k + 1;
		for (j = (n < pat.len()) ? n : pat.len(); j > 0; j--) begin
			ok = 1'b1;
			for (t = 0; t < j; t++) begin
				if (s[n - j + t] != pat[t]) begin
					ok = 1'b0;
				end
			end
			if (ok) begin
				return j;
			end
		end
		return 0;
	endfunction

	// Computes the output items caused by one input byte into fresh.
	task automatic predict_strip(logic [7:0] c, logic last);
		string sm, em;
		int k, j, e, t;
		sm = open_mark[cur_kind];
		em = close_mark[cur_kind];
		fresh.delete();
		if (!in_region) begin
			k = (open_held < sm.len()) ? open_held : 0;
			j = advance(sm, k, c);
			for (t = 0; t < k + 1 - j; t++) begin
				fresh = {fresh, mk_out((t < k) ? sm[t] : c, 1'b1)};
			end
			if (j == sm.len()) begin
				// The end marker may already start inside the start marker.
				e = 0;
				for (t = 0; t < sm.len() && e < em.len(); t++) begin
					e = advance(em, e, sm[t]);
				end
				open_held = 0;
				in_region = (e < em.len());
				close_seen = in_region ? e : 0;
			end else begin
				open_held = j;
			end
		end else begin
			e = advance(em, close_seen, c);
			if (e >= em.len()) begin
				in_region = 1'b0;
				open_held = 0;
				close_seen = 0;
			end else begin
				close_seen = e;
			end
		end
		if (last) begin
			if (!in_region) begin
				for (t = 0; t < open_held; t++) begin
					fresh = {fresh, mk_out(sm[t], 1'b1)};
				end
			end
			if (fresh.size() == 0) begin
				fresh = {fresh, mk_out(8'h00, 1'b0)};
			end
			in_region = 1'b0;
			open_held = 0;
			close_seen = 0;
		end
		if (fresh.size() != 0) begin
			fresh[fresh.size() - 1].run_last = 1'b1;
			fresh[fresh.size() - 1].stream_end = last;
		end
	endtask

	task automatic send_byte(logic [7:0] b, logic last, logic typed,
			mrs_pkg::out_item_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				up_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		up_valid <= 1'b1;
		up_item <= '{data_byte: b, stream_last: last};
		do @(posedge clk); while (up_stall);
		predict_strip(b, last);
		if (typed) begin
			expected_bytes = {expected_bytes, want};
		end else begin
			foreach (fresh[i]) expected_bytes = {expected_bytes, fresh[i]};
		end
	endtask

	// The mode changes only once the block has drained.
	task automatic set_kind(mrs_pkg::kind_t k);
		up_valid <= 1'b0;
		burst_left = 0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_kind = k;
		in_region = 1'b0;
		open_held = 0;
		close_seen = 0;
	endtask

	task automatic add_text();
		int n, t;
		n = $urandom_range(1, 5);
		for (t = 0; t < n; t++) begin
			if ($urandom_range(0, 2) == 0) begin
				stream_bytes = {stream_bytes, 8'($urandom_range(0, 255))};
			end else begin
				stream_bytes = {stream_bytes,
					alphabet[$urandom_range(0, alphabet.len() - 1)]};
			end
		end
	endtask

	task automatic add_mark(string m, int n);
		int t;
		for (t = 0; t < n; t++) begin
			stream_bytes = {stream_bytes, m[t]};
		end
	endtask

	// Mostly well-formed regions with random content, some cut short.
	task automatic make_stream(mrs_pkg::kind_t k);
		int rounds, r;
		string om, cm;
		om = open_mark[k];
		cm = close_mark[k];
		rounds = $urandom_range(1, 3);
		for (r = 0; r < rounds; r++) begin
			if ($urandom_range(0, 3) != 0) add_text();
			if ($urandom_range(0, 3) != 0) begin
				add_mark(om, om.len());
			end else begin
				add_mark(om, $urandom_range(1, om.len() - 1));
			end
			if ($urandom_range(0, 1) != 0) add_text();
			if ($urandom_range(0, 3) != 0) begin
				add_mark(cm, cm.len());
			end else begin
				add_mark(cm, $urandom_range(1, cm.len() - 1));
			end
		end
		if ($urandom_range(0, 1) != 0) add_text();
	endtask

	initial begin
		int ph, sent;
		mrs_pkg::kind_t k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				set_kind(mrs_pkg::kind_t'(plan[i].value[1:0]));
			end else begin
				send_byte(plan[i].value, plan[i].last, plan[i].typed, plan[i].want);
			end
		end
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			k = (ph < 4) ? mrs_pkg::kind_t'(2'(ph)) :
				mrs_pkg::kind_t'(2'($urandom_range(0, 3)));
			set_kind(k);
			if (ph == 2) begin
				hold_req = 1'b1;
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				stream_bytes.delete();
				make_stream(k);
				foreach (stream_bytes[i]) begin
					send_byte(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, '0);
				end
				sent += stream_bytes.size();
			end
		end
		up_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Receiver: a changing stall pattern, plus one long hold-off that fills the block.
	int  stall_tick = 0;
	int  stall_mode = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 32 == 0) begin
			stall_mode <= $urandom_range(0, 3);
		end
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			dn_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dn_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: dn_stall <= 1'b0;
				1: dn_stall <= 1'($urandom_range(0, 1));
				2: dn_stall <= (stall_tick % 3 == 0);
				default: dn_stall <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	mrs_pkg::out_item_t oldest;
	always @(posedge clk) begin
		if (arst_n && dn_valid && !dn_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected item: out_byte %h byte_valid %b", dn_item.out_byte,
					dn_item.byte_valid);
				fails++;
			end else begin
				oldest = expected_bytes.pop_front();
				if (dn_item.out_byte !== oldest.out_byte) begin
					$error("out_byte: expected %h, got %h", oldest.out_byte, dn_item.out_byte);
					fails++;
				end
				if (dn_item.byte_valid !== oldest.byte_valid) begin
					$error("byte_valid: expected %b, got %b", oldest.byte_valid,
						dn_item.byte_valid);
					fails++;
				end
				if (dn_item.run_last !== oldest.run_last) begin
					$error("run_last: expected %b, got %b", oldest.run_last, dn_item.run_last);
					fails++;
				end
				if (dn_item.stream_end !== oldest.stream_end) begin
					$error("stream_end: expected %b, got %b", oldest.stream_end,
						dn_item.stream_end);
					fails++;
				end
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((up_valid && !up_stall) || (dn_valid && !dn_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

`default_nettype wire

// File: sim.f
design/mrs_pkg.sv
design/mrs_queue.sv
design/mrs_front.sv
design/mrs_back.sv
design/markup_region_stripper_core.sv
design/mrs_checker.sv
test/testbench.sv
